[rtl/ccsmv_pkg.sv]
// shared types, widths and command codes for the complex csr matrix-vector block
`default_nettype none

package ccsmv_pkg;

    localparam int VSIZE       = 1024;
    localparam int ROW_W       = (VSIZE > 2) ? $clog2(VSIZE) : 1;
    localparam int IDX_W       = 10;
    localparam int STORE_DEPTH = 1 << IDX_W;
    localparam int VAL_W       = 32;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = 64;
    localparam int FRAC_BITS   = 24;
    localparam int SUM_W       = PROD_W + 2;
    localparam int TERM_W      = SUM_W - FRAC_BITS;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_MAC   = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } t_cplx;

    typedef struct packed {
        logic close;
        logic row_end;
    } t_tag;

endpackage

`default_nettype wire

[rtl/ccsmv_if.sv]
// input and output channel interfaces
`default_nettype none

interface ccsmv_in_if import ccsmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value_real;
    logic signed [VAL_W-1:0] value_imag;
    logic                    row_end;

    modport source (output valid, cmd, index, value_real, value_imag, row_end, input ready);
    modport sink (input valid, cmd, index, value_real, value_imag, row_end, output ready);
endinterface

interface ccsmv_out_if import ccsmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        row_number;
    logic signed [VAL_W-1:0] sum_real;
    logic signed [VAL_W-1:0] sum_imag;
    logic                    final_row;

    modport source (output valid, row_number, sum_real, sum_imag, final_row, input ready);
    modport sink (input valid, row_number, sum_real, sum_imag, final_row, output ready);
endinterface

`default_nettype wire

[rtl/ccsmv_vstore.sv]
// dense vector store, one write or one registered read per cycle
`default_nettype none

module ccsmv_vstore import ccsmv_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_addr,
    input  wire t_cplx            i_wr_data,
    output t_cplx                 o_rd_data
);

    t_cplx r_mem [STORE_DEPTH];
    t_cplx r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/ccsmv_cmac.sv]
// complex multiply stage and rounded term stage
`default_nettype none

module ccsmv_cmac import ccsmv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_tag               i_tag,
    input  wire t_cplx              i_mat,
    input  wire t_cplx              i_vec,
    output logic                    o_ready,
    output logic                    o_valid,
    output t_tag                    o_tag,
    output logic signed [TERM_W-1:0] o_term_re,
    output logic signed [TERM_W-1:0] o_term_im,
    input  wire logic               i_ready
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    logic                     r2_v;
    t_tag                     r2_tag;
    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ri;
    logic signed [PROD_W-1:0] r_p_ir;

    logic                     r3_v;
    t_tag                     r3_tag;
    logic signed [TERM_W-1:0] r_term_re;
    logic signed [TERM_W-1:0] r_term_im;

    logic                     w_ready2;
    logic                     w_ready3;
    logic signed [SUM_W-1:0]  w_sum_re;
    logic signed [SUM_W-1:0]  w_sum_im;

    assign w_ready3 = !r3_v || i_ready;
    assign w_ready2 = !r2_v || w_ready3;
    assign o_ready  = w_ready2;

    // exact sum of two products plus half, floor by arithmetic shift
    assign w_sum_re = SUM_W'(r_p_rr) - SUM_W'(r_p_ii) + ROUND_HALF;
    assign w_sum_im = SUM_W'(r_p_ri) + SUM_W'(r_p_ir) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_ready2) begin
                r2_v <= i_valid;
            end
            if (w_ready3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2) begin
            r2_tag <= i_tag;
            r_p_rr <= $signed(i_mat.re) * $signed(i_vec.re);
            r_p_ii <= $signed(i_mat.im) * $signed(i_vec.im);
            r_p_ri <= $signed(i_mat.re) * $signed(i_vec.im);
            r_p_ir <= $signed(i_mat.im) * $signed(i_vec.re);
        end
        if (w_ready3) begin
            r3_tag    <= r2_tag;
            r_term_re <= w_sum_re[SUM_W-1:FRAC_BITS];
            r_term_im <= w_sum_im[SUM_W-1:FRAC_BITS];
        end
    end

    assign o_valid   = r3_v;
    assign o_tag     = r3_tag;
    assign o_term_re = r_term_re;
    assign o_term_im = r_term_im;

endmodule

`default_nettype wire

[rtl/ccsmv_accum.sv]
// row accumulator, row counter and output register
`default_nettype none

module ccsmv_accum import ccsmv_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_tag                i_tag,
    input  wire logic signed [TERM_W-1:0] i_term_re,
    input  wire logic signed [TERM_W-1:0] i_term_im,
    output logic                     o_ready,
    ccsmv_out_if.source              o_out
);

    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic [ROW_W-1:0]        r_row;
    logic                    r_o_valid;
    logic [IDX_W-1:0]        r_o_row;
    logic signed [VAL_W-1:0] r_o_re;
    logic signed [VAL_W-1:0] r_o_im;
    logic                    r_o_final;

    logic                    w_emit;
    logic                    w_out_free;
    logic                    w_fire;
    logic signed [ACC_W-1:0] n_acc_re;
    logic signed [ACC_W-1:0] n_acc_im;
    logic [ROW_W+IDX_W-1:0]  w_row_ext;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [TERM_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_narrow(
        input logic signed [ACC_W-1:0] a
    );
        if (a[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){a[ACC_W-1]}}) begin
            sat_narrow = a[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            sat_narrow = a[VAL_W-1:0];
        end
    endfunction

    assign w_emit     = i_tag.close || i_tag.row_end;
    assign w_out_free = !r_o_valid || o_out.ready;
    assign o_ready    = !w_emit || w_out_free;
    assign w_fire     = i_valid && o_ready;
    assign n_acc_re   = sat_add(r_acc_re, i_term_re);
    assign n_acc_im   = sat_add(r_acc_im, i_term_im);
    assign w_row_ext  = {{IDX_W{1'b0}}, r_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re  <= '0;
            r_acc_im  <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_fire && w_emit) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_fire) begin
                if (w_emit) begin
                    r_acc_re  <= '0;
                    r_acc_im  <= '0;
                    if (r_row == ROW_W'(VSIZE - 1)) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_acc_re <= n_acc_re;
                    r_acc_im <= n_acc_im;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_o_row   <= w_row_ext[IDX_W-1:0];
            r_o_final <= (r_row == ROW_W'(VSIZE - 1));
            if (i_tag.close) begin
                r_o_re <= '0;
                r_o_im <= '0;
            end else begin
                r_o_re <= sat_narrow(n_acc_re);
                r_o_im <= sat_narrow(n_acc_im);
            end
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.row_number = r_o_row;
    assign o_out.sum_real   = r_o_re;
    assign o_out.sum_imag   = r_o_im;
    assign o_out.final_row  = r_o_final;

endmodule

`default_nettype wire

[rtl/complex_csr_sparse_matrix_vector_top.sv]
// top level of the complex csr sparse matrix times dense vector block
`default_nettype none

// Streams a complex CSR matrix against a dense complex vector held in a
// 1024-entry store. A row result passes the store read, multiply, round
// and accumulate registers after the word that closes the row. One word is
// taken every cycle at the rate set by the accumulator, which takes one
// rounded complex product per cycle unless a row end meets a full output.
// Load words write the store at once, so a nonzero may follow a load of its
// column in the next cycle; a column not loaded since reset reads undefined.
module complex_csr_sparse_matrix_vector_top import ccsmv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ccsmv_in_if.sink   i_in,
    ccsmv_out_if.source o_out
);

    logic       r1_v;
    t_tag       r1_tag;
    t_cplx      r1_mat;

    t_cplx      w_vec;
    t_cplx      w_in_val;
    t_tag       w_in_tag;
    logic       w_accept;
    logic       w_cmac_ready;
    logic       w_keep;

    logic                     w_s3_v;
    t_tag                     w_s3_tag;
    logic signed [TERM_W-1:0] w_term_re;
    logic signed [TERM_W-1:0] w_term_im;
    logic                     w_acc_ready;

    assign w_accept      = i_in.valid && i_in.ready;
    assign i_in.ready    = !r1_v || w_cmac_ready;
    assign w_in_val.re   = i_in.value_real;
    assign w_in_val.im   = i_in.value_imag;
    assign w_keep        = (i_in.cmd == CMD_MAC) || (i_in.cmd == CMD_CLOSE);
    assign w_in_tag.close   = (i_in.cmd == CMD_CLOSE);
    assign w_in_tag.row_end = i_in.row_end;

    ccsmv_vstore u_vstore (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_in.cmd == CMD_LOAD)),
        .i_rd_en   (w_accept && (i_in.cmd == CMD_MAC)),
        .i_addr    (i_in.index),
        .i_wr_data (w_in_val),
        .o_rd_data (w_vec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_in.ready) begin
            r1_v <= i_in.valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_tag <= w_in_tag;
            r1_mat <= w_in_val;
        end
    end

    ccsmv_cmac u_cmac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r1_v),
        .i_tag     (r1_tag),
        .i_mat     (r1_mat),
        .i_vec     (w_vec),
        .o_ready   (w_cmac_ready),
        .o_valid   (w_s3_v),
        .o_tag     (w_s3_tag),
        .o_term_re (w_term_re),
        .o_term_im (w_term_im),
        .i_ready   (w_acc_ready)
    );

    ccsmv_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s3_v),
        .i_tag     (w_s3_tag),
        .i_term_re (w_term_re),
        .i_term_im (w_term_im),
        .o_ready   (w_acc_ready),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r1_v |-> i_in.ready)
        else $error("input not ready with empty first stage");

    a_stage1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_in.cmd == CMD_MAC) || (i_in.cmd == CMD_CLOSE))) |=> r1_v)
        else $error("row word lost at first stage");

    a_final_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.final_row) |-> (o_out.row_number == IDX_W'(VSIZE - 1)))
        else $error("final row flag on wrong row");
`endif

endmodule

`default_nettype wire
